FILE: rtl/dpps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpps_pkg;

   localparam int FRAC_BITS      = 8;
   localparam int COORD_W        = 16;
   localparam int DELTA_W        = COORD_W + 1;
   localparam int SPAN_LEN_W     = 10;
   localparam int SPAN_REGS      = 4;
   localparam int IDX_W          = 2;
   localparam int USE_W          = IDX_W + 1;
   localparam int LEN_W          = SPAN_LEN_W + FRAC_BITS;
   localparam int SEG_W          = DELTA_W + FRAC_BITS;
   localparam int PERIOD_W       = LEN_W + IDX_W;
   localparam int SUM_W          = 2 * DELTA_W;
   localparam int PIECE_W        = 7;
   localparam int THICK_W        = 7;
   localparam int COLOR_W        = 32;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int DEF_MAX_SPANS  = 4;
   localparam int DEF_MAX_PIECES = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPAN_COUNT    = 3'd0,
      CSR_DRAW_MASK     = 3'd1,
      CSR_SPAN_LENGTH_0 = 3'd2,
      CSR_SPAN_LENGTH_1 = 3'd3,
      CSR_SPAN_LENGTH_2 = 3'd4,
      CSR_SPAN_LENGTH_3 = 3'd5,
      CSR_LINE_THICK    = 3'd6,
      CSR_LINE_COLOR    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      first_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [THICK_W-1:0]        stroke_thickness;
      logic [COLOR_W-1:0]        stroke_color;
      logic                      last_piece;
      logic                      pieces_dropped;
   } rsp_type;

   typedef struct packed {
      logic [USE_W-1:0]                      span_use;
      logic [SPAN_REGS-1:0]                  draw_mask;
      logic [SPAN_REGS-1:0][SPAN_LEN_W-1:0]  span_len;
      logic [THICK_W-1:0]                    thickness;
      logic [COLOR_W-1:0]                    color;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [SEG_W-1:0]          seg_len;
      logic [IDX_W-1:0]          start_index;
      logic [LEN_W-1:0]          start_offset;
      logic [PIECE_W-1:0]        pieces;
      logic                      dropped;
   } job_type;

   typedef struct packed {
      logic [LEN_W-1:0] step;
      logic             draw;
      logic [IDX_W-1:0] index;
      logic [LEN_W-1:0] offset;
   } step_type;

   function automatic step_type phase_step(cfg_type cfg, logic [IDX_W-1:0] idx,
                                           logic [LEN_W-1:0] off,
                                           logic [SEG_W-1:0] seg_off,
                                           logic [SEG_W-1:0] seg_len);
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] span_rem;
      logic [LEN_W-1:0] step;
      logic [SEG_W-1:0] left;
      logic [LEN_W:0]   sum;
      step_type         r;
      len      = {cfg.span_len[idx], {FRAC_BITS{1'b0}}};
      span_rem = (off < len) ? len - off : '0;
      left     = seg_len - seg_off;
      step     = (SEG_W'(span_rem) < left) ? span_rem : left[LEN_W-1:0];
      sum      = {1'b0, off} + {1'b0, step};
      r.step   = step;
      r.draw   = cfg.draw_mask[idx] && (step != '0);
      if (sum >= {1'b0, len}) begin
         r.offset = '0;
         r.index  = (({1'b0, idx} + USE_W'(1)) == cfg.span_use) ? '0 : idx + IDX_W'(1);
      end else begin
         r.offset = sum[LEN_W-1:0];
         r.index  = idx;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dpps_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dpps_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dpps_pkg::job_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output dpps_pkg::job_type      pop_data,
   output logic                   empty
);

   dpps_pkg::job_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !full) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop && !empty) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push && !full, pop && !empty})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dpps_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dpps_front #(
   parameter int MAX_PIECES = dpps_pkg::DEF_MAX_PIECES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dpps_pkg::cfg_type cfg,
   input  wire logic              req_push,
   input  wire dpps_pkg::req_type req_data,
   output logic                   req_full,
   output logic                   job_push,
   output dpps_pkg::job_type      job_data,
   input  wire logic              job_full
);

   localparam int SEG_W    = dpps_pkg::SEG_W;
   localparam int LEN_W    = dpps_pkg::LEN_W;
   localparam int IDX_W    = dpps_pkg::IDX_W;
   localparam int PERIOD_W = dpps_pkg::PERIOD_W;
   localparam int SUM_W    = dpps_pkg::SUM_W;
   localparam int ROOT_W   = SEG_W + 3;
   localparam int PIECE_W  = dpps_pkg::PIECE_W;

   typedef enum logic [6:0] {
      F_IDLE   = 7'b0000001,
      F_SQUARE = 7'b0000010,
      F_ROOT   = 7'b0000100,
      F_CHECK  = 7'b0001000,
      F_WALK   = 7'b0010000,
      F_MOD    = 7'b0100000,
      F_PUSH   = 7'b1000000
   } fstate_type;

   fstate_type state_ff, state_in;
   logic signed [dpps_pkg::COORD_W-1:0] prev_x_ff, prev_y_ff, prev_x_in, prev_y_in;
   logic signed [dpps_pkg::COORD_W-1:0] x0_ff, y0_ff, x0_in, y0_in;
   logic have_prev_ff, have_prev_in;
   logic [IDX_W-1:0] idx_ff, idx_in, start_idx_ff, start_idx_in;
   logic [LEN_W-1:0] off_ff, off_in, start_off_ff, start_off_in;
   logic signed [dpps_pkg::DELTA_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SUM_W-1:0] sq_ff, sq_in;
   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [SEG_W-1:0] root_ff, root_in;
   logic [SEG_W-1:0] seg_len_ff, seg_len_in, seg_off_ff, seg_off_in;
   logic [PIECE_W-1:0] pieces_ff, pieces_in;
   logic dropped_ff, dropped_in;
   logic [SEG_W-1:0] mnum_ff, mnum_in;
   logic [PERIOD_W:0] mrem_ff, mrem_in;
   logic [4:0] cnt_ff, cnt_in;

   logic [PERIOD_W-1:0] period;
   logic [ROOT_W-1:0] rem_sh, trial;
   logic [PERIOD_W:0] mrem_sh;
   logic [SEG_W-1:0] seg_next;
   dpps_pkg::step_type st;

   always_comb begin
      period = '0;
      for (int i = 0; i < dpps_pkg::SPAN_REGS; i++) begin
         if (dpps_pkg::USE_W'(i) < cfg.span_use) begin
            period = period + PERIOD_W'({cfg.span_len[i], {dpps_pkg::FRAC_BITS{1'b0}}});
         end
      end
   end

   assign req_full = (state_ff != F_IDLE);
   assign rem_sh   = {rem_ff[ROOT_W-3:0], sq_ff[SUM_W-1:SUM_W-2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign mrem_sh  = {mrem_ff[PERIOD_W-1:0], mnum_ff[SEG_W-1]};
   assign st       = dpps_pkg::phase_step(cfg, idx_ff, off_ff, seg_off_ff, seg_len_ff);
   assign seg_next = seg_off_ff + SEG_W'(st.step);
   assign job_push = (state_ff == F_PUSH) && !job_full;

   always_comb begin
      job_data.x0           = x0_ff;
      job_data.y0           = y0_ff;
      job_data.dx           = dx_ff;
      job_data.dy           = dy_ff;
      job_data.seg_len      = seg_len_ff;
      job_data.start_index  = start_idx_ff;
      job_data.start_offset = start_off_ff;
      job_data.pieces       = pieces_ff;
      job_data.dropped      = dropped_ff;
   end

   always_comb begin
      state_in     = state_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      have_prev_in = have_prev_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      start_idx_in = start_idx_ff;
      start_off_in = start_off_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      seg_len_in   = seg_len_ff;
      seg_off_in   = seg_off_ff;
      pieces_in    = pieces_ff;
      dropped_in   = dropped_ff;
      mnum_in      = mnum_ff;
      mrem_in      = mrem_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               prev_x_in = req_data.point_x;
               prev_y_in = req_data.point_y;
               x0_in     = prev_x_ff;
               y0_in     = prev_y_ff;
               if (req_data.first_point || !have_prev_ff) begin
                  have_prev_in = 1'b1;
                  idx_in       = '0;
                  off_in       = '0;
               end else if (cfg.span_use != '0 && period != '0) begin
                  dx_in    = dpps_pkg::DELTA_W'(req_data.point_x) - dpps_pkg::DELTA_W'(prev_x_ff);
                  dy_in    = dpps_pkg::DELTA_W'(req_data.point_y) - dpps_pkg::DELTA_W'(prev_y_ff);
                  state_in = F_SQUARE;
               end
            end
         end
         F_SQUARE: begin
            sq_in    = SUM_W'(dx_ff * dx_ff) + SUM_W'(dy_ff * dy_ff);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = F_ROOT;
         end
         F_ROOT: begin
            sq_in = {sq_ff[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[SEG_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[SEG_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SEG_W - 1)) begin
               state_in = F_CHECK;
            end
         end
         F_CHECK: begin
            seg_len_in = root_ff;
            seg_off_in = '0;
            pieces_in  = '0;
            dropped_in = 1'b0;
            if (root_ff == '0) begin
               state_in = F_IDLE;
            end else begin
               if (dpps_pkg::USE_W'(idx_ff) >= cfg.span_use) begin
                  idx_in       = '0;
                  off_in       = '0;
                  start_idx_in = '0;
                  start_off_in = '0;
               end else begin
                  start_idx_in = idx_ff;
                  start_off_in = off_ff;
               end
               state_in = F_WALK;
            end
         end
         F_WALK: begin
            idx_in     = st.index;
            off_in     = st.offset;
            seg_off_in = seg_next;
            if (st.draw && !dropped_ff && pieces_ff == PIECE_W'(MAX_PIECES)) begin
               dropped_in = 1'b1;
               mnum_in    = seg_len_ff - seg_next;
               mrem_in    = '0;
               cnt_in     = '0;
               state_in   = F_MOD;
            end else begin
               if (st.draw && !dropped_ff) begin
                  pieces_in = pieces_ff + PIECE_W'(1);
               end
               if (seg_next == seg_len_ff) begin
                  state_in = (pieces_in != '0) ? F_PUSH : F_IDLE;
               end
            end
         end
         F_MOD: begin
            mnum_in = {mnum_ff[SEG_W-2:0], 1'b0};
            mrem_in = (mrem_sh >= {1'b0, period}) ? mrem_sh - {1'b0, period} : mrem_sh;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SEG_W - 1)) begin
               seg_off_in = seg_len_ff - SEG_W'(mrem_in);
               state_in   = (mrem_in == '0) ? F_PUSH : F_WALK;
            end
         end
         F_PUSH: begin
            if (!job_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         idx_ff       <= '0;
         off_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         idx_ff       <= idx_in;
         off_ff       <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      start_idx_ff <= start_idx_in;
      start_off_ff <= start_off_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      seg_len_ff   <= seg_len_in;
      seg_off_ff   <= seg_off_in;
      pieces_ff    <= pieces_in;
      dropped_ff   <= dropped_in;
      mnum_ff      <= mnum_in;
      mrem_ff      <= mrem_in;
      cnt_ff       <= cnt_in;
   end

endmodule

`default_nettype wire

FILE: rtl/dpps_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dpps_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dpps_pkg::cfg_type cfg,
   input  wire logic              job_empty,
   input  wire dpps_pkg::job_type job_data,
   output logic                   job_pop,
   output logic                   rsp_empty,
   output dpps_pkg::rsp_type      rsp_data,
   input  wire logic              rsp_pop
);

   localparam int SEG_W   = dpps_pkg::SEG_W;
   localparam int LEN_W   = dpps_pkg::LEN_W;
   localparam int IDX_W   = dpps_pkg::IDX_W;
   localparam int COORD_W = dpps_pkg::COORD_W;
   localparam int DELTA_W = dpps_pkg::DELTA_W;
   localparam int NUM_W   = DELTA_W + SEG_W;
   localparam int QUO_W   = COORD_W;
   localparam int PIECE_W = dpps_pkg::PIECE_W;
   localparam int B_W     = COORD_W + 2;

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_WALK  = 6'b000010,
      B_MUL   = 6'b000100,
      B_DIV   = 6'b001000,
      B_ROUND = 6'b010000,
      B_EMIT  = 6'b100000
   } bstate_type;

   bstate_type state_ff, state_in;
   dpps_pkg::job_type job_ff, job_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] off_ff, off_in;
   logic [SEG_W-1:0] seg_off_ff, seg_off_in, p_start_ff, p_start_in, p_end_ff, p_end_in;
   logic [PIECE_W-1:0] emitted_ff, emitted_in;
   logic [1:0] sel_ff, sel_in;
   logic neg_ff, neg_in;
   logic [SEG_W-1:0] drem_ff, drem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [3:0] dcnt_ff, dcnt_in;
   logic [3:0][COORD_W-1:0] coord_ff, coord_in;
   dpps_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;

   dpps_pkg::step_type st;
   logic signed [DELTA_W-1:0] d_sel;
   logic signed [COORD_W-1:0] a_sel;
   logic [SEG_W-1:0] pos_sel;
   logic [DELTA_W-1:0] d_abs;
   logic [NUM_W-1:0] num;
   logic [SEG_W:0] drem_sh;
   logic signed [B_W-1:0] q_s, b_val, res;
   logic [SEG_W-1:0] r_f;
   logic [SEG_W:0] r2;
   logic up;
   logic load_out;

   assign st = dpps_pkg::phase_step(cfg, idx_ff, off_ff, seg_off_ff, job_ff.seg_len);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign job_pop   = (state_ff == B_IDLE) && !job_empty;
   assign load_out  = (state_ff == B_EMIT) && (!out_valid_ff || rsp_pop);

   always_comb begin
      a_sel   = sel_ff[0] ? job_ff.y0 : job_ff.x0;
      d_sel   = sel_ff[0] ? job_ff.dy : job_ff.dx;
      pos_sel = sel_ff[1] ? p_end_ff : p_start_ff;
      d_abs   = d_sel[DELTA_W-1] ? DELTA_W'(-d_sel) : DELTA_W'(d_sel);
      num     = NUM_W'(d_abs * pos_sel);
      drem_sh = {drem_ff, quo_ff[QUO_W-1]};
      q_s     = neg_ff ? -(B_W'(quo_ff) + B_W'(drem_ff != '0)) : B_W'(quo_ff);
      r_f     = (neg_ff && drem_ff != '0) ? job_ff.seg_len - drem_ff : drem_ff;
      r2      = {r_f, 1'b0};
      b_val   = B_W'(a_sel) + q_s;
      up      = (r2 > {1'b0, job_ff.seg_len}) ||
                (r2 == {1'b0, job_ff.seg_len} && !b_val[B_W-1]);
      res     = b_val + B_W'(up);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      seg_off_in   = seg_off_ff;
      p_start_in   = p_start_ff;
      p_end_in     = p_end_ff;
      emitted_in   = emitted_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      drem_in      = drem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      coord_in     = coord_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_in     = job_data;
               idx_in     = job_data.start_index;
               off_in     = job_data.start_offset;
               seg_off_in = '0;
               emitted_in = '0;
               state_in   = B_WALK;
            end
         end
         B_WALK: begin
            idx_in     = st.index;
            off_in     = st.offset;
            seg_off_in = seg_off_ff + SEG_W'(st.step);
            if (st.draw) begin
               p_start_in = seg_off_ff;
               p_end_in   = seg_off_ff + SEG_W'(st.step);
               sel_in     = 2'd0;
               state_in   = B_MUL;
            end
         end
         B_MUL: begin
            neg_in   = d_sel[DELTA_W-1];
            drem_in  = num[NUM_W-2:QUO_W];
            quo_in   = num[QUO_W-1:0];
            dcnt_in  = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            if (drem_sh >= {1'b0, job_ff.seg_len}) begin
               drem_in = SEG_W'(drem_sh - {1'b0, job_ff.seg_len});
               quo_in  = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               drem_in = drem_sh[SEG_W-1:0];
               quo_in  = {quo_ff[QUO_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(QUO_W - 1)) begin
               state_in = B_ROUND;
            end
         end
         B_ROUND: begin
            coord_in[sel_ff] = res[COORD_W-1:0];
            sel_in           = sel_ff + 2'd1;
            state_in         = (sel_ff == 2'd3) ? B_EMIT : B_MUL;
         end
         B_EMIT: begin
            if (load_out) begin
               out_in.start_x          = coord_ff[0];
               out_in.start_y          = coord_ff[1];
               out_in.end_x            = coord_ff[2];
               out_in.end_y            = coord_ff[3];
               out_in.stroke_thickness = cfg.thickness;
               out_in.stroke_color     = cfg.color;
               out_in.last_piece       = (emitted_ff + PIECE_W'(1) == job_ff.pieces);
               out_in.pieces_dropped   = job_ff.dropped;
               out_valid_in            = 1'b1;
               emitted_in              = emitted_ff + PIECE_W'(1);
               state_in = (emitted_ff + PIECE_W'(1) == job_ff.pieces) ? B_IDLE : B_WALK;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      idx_ff     <= idx_in;
      off_ff     <= off_in;
      seg_off_ff <= seg_off_in;
      p_start_ff <= p_start_in;
      p_end_ff   <= p_end_in;
      emitted_ff <= emitted_in;
      sel_ff     <= sel_in;
      neg_ff     <= neg_in;
      drem_ff    <= drem_in;
      quo_ff     <= quo_in;
      dcnt_ff    <= dcnt_in;
      coord_ff   <= coord_in;
      out_ff     <= out_in;
   end

   a_walk_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WALK) |-> (emitted_ff < job_ff.pieces))
      else $error("walk running with no pieces left");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff == B_WALK))
      else $error("job taken outside idle");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (load_out && out_in.last_piece) |=> (state_ff == B_IDLE))
      else $error("last item did not end the job");

endmodule

`default_nettype wire

FILE: rtl/dash_pattern_polyline_splitter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          direction  accepted when
// req       req_push req_full req_data     in         req_push && !req_full
// rsp       rsp_empty rsp_pop rsp_data     out        rsp_pop && !rsp_empty
// csr       csr_valid csr_ready csr_index   in         csr_valid && csr_ready
//           csr_data
//
// Front: squares the segment, takes the root bit by bit, checks it, walks the pattern step by
// step and pushes the job; a segment over the piece limit skips whole pattern periods.
// Back: per item out, the four coordinates run through the shared 16-step divider in turn.
// Reset is synchronous and clears phase, previous point, queue and output register.
// A two-entry queue between front and back and the output register let each side stall alone.

module dash_pattern_polyline_splitter_core #(
   parameter int MAX_SPANS  = dpps_pkg::DEF_MAX_SPANS,
   parameter int MAX_PIECES = dpps_pkg::DEF_MAX_PIECES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   input  wire dpps_pkg::req_type                   req_data,
   output logic                                     req_full,
   output logic                                     rsp_empty,
   output dpps_pkg::rsp_type                        rsp_data,
   input  wire logic                                rsp_pop,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dpps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [dpps_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SPAN_CAP = (MAX_SPANS < dpps_pkg::SPAN_REGS) ? MAX_SPANS : dpps_pkg::SPAN_REGS;

   logic [2:0] span_count_ff;
   logic [dpps_pkg::SPAN_REGS-1:0] draw_mask_ff;
   logic [dpps_pkg::SPAN_REGS-1:0][dpps_pkg::SPAN_LEN_W-1:0] span_len_ff;
   logic [dpps_pkg::THICK_W-1:0] thick_ff;
   logic [dpps_pkg::COLOR_W-1:0] color_ff;
   dpps_pkg::cfg_type cfg;

   logic job_push, job_full, job_pop, job_empty;
   dpps_pkg::job_type job_in_data, job_out_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg.span_use  = (span_count_ff > 3'(SPAN_CAP)) ? dpps_pkg::USE_W'(SPAN_CAP)
                                                     : span_count_ff;
      cfg.draw_mask = draw_mask_ff;
      cfg.span_len  = span_len_ff;
      cfg.thickness = thick_ff;
      cfg.color     = color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_count_ff  <= 3'd0;
         draw_mask_ff   <= 4'd1;
         span_len_ff[0] <= 10'd12;
         span_len_ff[1] <= 10'd6;
         span_len_ff[2] <= 10'd3;
         span_len_ff[3] <= 10'd4;
         thick_ff       <= 7'd1;
         color_ff       <= '0;
      end else if (csr_valid) begin
         unique case (dpps_pkg::csr_index_type'(csr_index))
            dpps_pkg::CSR_SPAN_COUNT:    span_count_ff  <= csr_data[2:0];
            dpps_pkg::CSR_DRAW_MASK:     draw_mask_ff   <= csr_data[3:0];
            dpps_pkg::CSR_SPAN_LENGTH_0: span_len_ff[0] <= csr_data[9:0];
            dpps_pkg::CSR_SPAN_LENGTH_1: span_len_ff[1] <= csr_data[9:0];
            dpps_pkg::CSR_SPAN_LENGTH_2: span_len_ff[2] <= csr_data[9:0];
            dpps_pkg::CSR_SPAN_LENGTH_3: span_len_ff[3] <= csr_data[9:0];
            dpps_pkg::CSR_LINE_THICK:    thick_ff       <= csr_data[6:0];
            dpps_pkg::CSR_LINE_COLOR:    color_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   dpps_front #(
      .MAX_PIECES (MAX_PIECES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_push (job_push),
      .job_data (job_in_data),
      .job_full (job_full)
   );

   dpps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   dpps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire
